/* hw/rtl/fsom_pkg.sv */
// Package: shared types and constants of the flash sector overlay mapper.
`default_nettype none
package fsom_pkg;

    localparam int MAP_DEPTH_DEF     = 8192;
    localparam int SLOT_CAPACITY_DEF = 8192;
    localparam int DISK_CYLINDERS    = 203;
    localparam int DISK_SPT          = 12;
    localparam logic [13:0] DISK_RESET  = 14'(DISK_CYLINDERS * 2 * DISK_SPT);
    localparam logic [13:0] BASE_RESET  = 14'd0;
    localparam logic [13:0] SLOTS_RESET = 14'd8186;

    localparam logic [1:0] REG_DISK  = 2'd0;
    localparam logic [1:0] REG_BASE  = 2'd1;
    localparam logic [1:0] REG_SLOTS = 2'd2;

    localparam logic [1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [1:0] FUNC_COMMIT = 2'd1;
    localparam logic [1:0] FUNC_TICK   = 2'd2;

    typedef enum logic [1:0] {
        OP_LOOKUP, OP_COMMIT, OP_TICK, OP_BAD
    } t_op;

    typedef enum logic [1:0] {
        ST_OK, ST_RANGE, ST_FULL, ST_BUSY
    } t_status;

    typedef enum logic [2:0] {
        CMD_NONE, CMD_ERASE, CMD_COPY, CMD_PROGRAM, CMD_HEADER
    } t_cmd;

    typedef enum logic [1:0] {
        SRC_OVERLAY, SRC_BASE, SRC_ZERO
    } t_src;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_WALK, S_REBUILD, S_PEND
    } t_state;

    typedef struct packed {
        t_op         op;
        logic [12:0] sector;
        logic        in_range;
    } t_item;

    typedef struct packed {
        t_status     status;
        t_cmd        command;
        t_src        source;
        logic        bank;
        logic [12:0] slot;
        logic [12:0] from_slot;
        logic [12:0] record_sector;
        logic [31:0] sequence_res;
        logic        compacting;
        logic        last;
    } t_result;

endpackage
`default_nettype wire

/* hw/rtl/fsom_front.sv */
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none
module fsom_front #(
    parameter int MAP_DEPTH = fsom_pkg::MAP_DEPTH_DEF,
    localparam int LW = $clog2(MAP_DEPTH + 1)
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire logic [1:0]      i_func,
    input  wire logic [12:0]     i_sector,
    input  wire logic [LW-1:0]   i_lim,
    input  wire logic            i_busy,
    output logic                 o_q_valid,
    output fsom_pkg::t_item      o_q_item,
    input  wire logic            i_pop
);
    import fsom_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_item      cls;
    logic       push;

    always_comb begin
        unique case (i_func)
            FUNC_LOOKUP: cls.op = OP_LOOKUP;
            FUNC_COMMIT: cls.op = OP_COMMIT;
            FUNC_TICK:   cls.op = OP_TICK;
            default:     cls.op = OP_BAD;
        endcase
        cls.sector   = i_sector;
        cls.in_range = 32'(i_sector) < 32'(i_lim);
    end

    assign o_stall   = (r_cnt == 2'd2) || i_busy;
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/fsom_back.sv */
// Back end: sector map memory, slot allocation, compaction walk and result register.
`default_nettype none
module fsom_back #(
    parameter int MAP_DEPTH     = fsom_pkg::MAP_DEPTH_DEF,
    parameter int SLOT_CAPACITY = fsom_pkg::SLOT_CAPACITY_DEF,
    localparam int AW = $clog2(MAP_DEPTH),
    localparam int LW = $clog2(MAP_DEPTH + 1),
    localparam int SW = $clog2(SLOT_CAPACITY + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [LW-1:0] i_lim,
    input  wire logic [SW-1:0] i_slots,
    input  wire logic [13:0]   i_base,
    input  wire logic          i_q_valid,
    input  fsom_pkg::t_item    i_q_item,
    output logic               o_pop,
    output logic               o_busy,
    output logic               o_valid,
    input  wire logic          i_stall,
    output fsom_pkg::t_result  o_res
);
    import fsom_pkg::*;

    localparam int CW = (LW > SW) ? LW : SW;

    logic [CW:0]   r_map [MAP_DEPTH];
    logic [CW:0]   r_rd;

    t_state        r_state, n_state;
    t_op           r_op, n_op;
    logic [12:0]   r_sector, n_sector;
    logic          r_inrange, n_inrange;
    logic [LW-1:0] r_scan, n_scan;
    logic [LW-1:0] r_cursor, n_cursor;
    logic [CW-1:0] r_next, n_next;
    logic          r_bank, n_bank;
    logic [31:0]   r_seq, n_seq;
    logic          r_compact, n_compact;
    logic [12:0]   r_pending, n_pending;
    logic          r_out_valid, n_out_valid;
    t_result       r_res, n_res;

    logic          rd_en, we, emit, can_emit;
    logic [AW-1:0] rd_addr, wa;
    logic [CW:0]   wd;
    logic          slot_full, scan_in, pend_in;
    t_result       res;

    assign can_emit  = !r_out_valid || !i_stall;
    assign slot_full = 32'(r_next) >= 32'(i_slots);
    assign scan_in   = 32'(r_scan) < 32'(i_lim);
    assign pend_in   = 32'(r_pending) < 32'(i_lim);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_sector  = r_sector;
        n_inrange = r_inrange;
        n_scan    = r_scan;
        n_cursor  = r_cursor;
        n_next    = r_next;
        n_bank    = r_bank;
        n_seq     = r_seq;
        n_compact = r_compact;
        n_pending = r_pending;
        rd_en     = 1'b0;
        rd_addr   = '0;
        we        = 1'b0;
        wa        = '0;
        wd        = '0;
        emit      = 1'b0;
        o_pop     = 1'b0;
        res       = '0;
        res.last  = 1'b1;

        unique case (r_state)
            S_CLEAR: begin
                we     = 1'b1;
                wa     = AW'(r_scan);
                n_scan = r_scan + LW'(1);
                if (r_scan == LW'(MAP_DEPTH - 1)) begin
                    n_scan  = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_pop     = 1'b1;
                    n_op      = i_q_item.op;
                    n_sector  = i_q_item.sector;
                    n_inrange = i_q_item.in_range;
                    rd_en     = 1'b1;
                    if (i_q_item.op == OP_TICK && r_compact) begin
                        rd_addr = AW'(r_cursor);
                        n_scan  = r_cursor;
                        n_state = S_WALK;
                    end else begin
                        rd_addr = AW'(i_q_item.sector);
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    unique case (r_op)
                        OP_LOOKUP: begin
                            if (!r_inrange) begin
                                res.status = ST_RANGE;
                            end else if (r_rd[CW]) begin
                                res.bank = r_bank;
                                res.slot = 13'(r_rd[CW-1:0]);
                            end else if (14'(r_sector) < i_base) begin
                                res.source = SRC_BASE;
                            end else begin
                                res.source = SRC_ZERO;
                            end
                        end
                        OP_COMMIT: begin
                            if (r_compact) begin
                                res.status = ST_BUSY;
                            end else if (!r_inrange) begin
                                res.status = ST_RANGE;
                            end else if (slot_full) begin
                                n_compact   = 1'b1;
                                n_cursor    = '0;
                                n_pending   = r_sector;
                                n_next      = '0;
                                res.command = CMD_ERASE;
                                res.bank    = ~r_bank;
                            end else begin
                                res.command       = CMD_PROGRAM;
                                res.bank          = r_bank;
                                res.slot          = 13'(r_next);
                                res.record_sector = r_sector;
                                we                = 1'b1;
                                wa                = AW'(r_sector);
                                wd                = {1'b1, r_next};
                                n_next            = r_next + CW'(1);
                            end
                        end
                        default: res.status = ST_BUSY;
                    endcase
                end
            end
            S_WALK: begin
                if (!scan_in) begin
                    if (can_emit) begin
                        emit             = 1'b1;
                        res.command      = CMD_HEADER;
                        res.bank         = ~r_bank;
                        res.sequence_res = r_seq + 32'd1;
                        res.last         = 1'b0;
                        n_seq            = r_seq + 32'd1;
                        n_bank           = ~r_bank;
                        n_compact        = 1'b0;
                        n_cursor         = '0;
                        n_scan           = '0;
                        n_next           = '0;
                        rd_en            = 1'b1;
                        rd_addr          = '0;
                        n_state          = S_REBUILD;
                    end
                end else if (!r_rd[CW]) begin
                    n_scan  = r_scan + LW'(1);
                    rd_en   = 1'b1;
                    rd_addr = AW'(r_scan + LW'(1));
                end else if (can_emit) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (slot_full) begin
                        res.status = ST_FULL;
                        n_compact  = 1'b0;
                        n_cursor   = '0;
                    end else begin
                        res.command       = CMD_COPY;
                        res.bank          = ~r_bank;
                        res.slot          = 13'(r_next);
                        res.from_slot     = 13'(r_rd[CW-1:0]);
                        res.record_sector = 13'(r_scan);
                        n_next            = r_next + CW'(1);
                        n_cursor          = r_scan + LW'(1);
                    end
                end
            end
            S_REBUILD: begin
                we      = 1'b1;
                wa      = AW'(r_scan);
                rd_en   = 1'b1;
                rd_addr = AW'(r_scan + LW'(1));
                n_scan  = r_scan + LW'(1);
                if (r_rd[CW] && scan_in) begin
                    wd     = {1'b1, r_next};
                    n_next = r_next + CW'(1);
                end
                if (r_scan == LW'(MAP_DEPTH - 1)) begin
                    n_scan  = '0;
                    n_state = S_PEND;
                end
            end
            S_PEND: begin
                if (can_emit) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                    if (!pend_in) begin
                        res.status = ST_RANGE;
                    end else if (slot_full) begin
                        res.status = ST_FULL;
                    end else begin
                        res.command       = CMD_PROGRAM;
                        res.bank          = r_bank;
                        res.slot          = 13'(r_next);
                        res.record_sector = r_pending;
                        we                = 1'b1;
                        wa                = AW'(r_pending);
                        wd                = {1'b1, r_next};
                        n_next            = r_next + CW'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase

        res.compacting = n_compact;
        n_res          = emit ? res : r_res;
        n_out_valid    = emit || (r_out_valid && i_stall);
    end

    assign o_busy  = (r_state == S_CLEAR);
    assign o_valid = r_out_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_map[wa] <= wd;
        end
        if (rd_en) begin
            r_rd <= r_map[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_sector  <= n_sector;
        r_inrange <= n_inrange;
        r_res     <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_scan      <= '0;
            r_cursor    <= '0;
            r_next      <= '0;
            r_bank      <= 1'b0;
            r_seq       <= 32'd1;
            r_compact   <= 1'b0;
            r_pending   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_scan      <= n_scan;
            r_cursor    <= n_cursor;
            r_next      <= n_next;
            r_bank      <= n_bank;
            r_seq       <= n_seq;
            r_compact   <= n_compact;
            r_pending   <= n_pending;
            r_out_valid <= n_out_valid;
        end
    end

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CLEAR |-> !o_pop)
        else $error("queue popped during clearing pass");

    a_cursor_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_compact |-> r_cursor == '0)
        else $error("walk cursor nonzero outside compaction");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !we)
        else $error("map written while idle");

    a_header_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.last |-> (r_state == S_REBUILD || r_state == S_PEND))
        else $error("non-final result outside bank switch");

endmodule
`default_nettype wire

/* hw/rtl/flash_sector_overlay_mapper_top.sv */
// Top level: configuration registers and the front and back ends of the mapper.
// Lookup and commit: map read at pop, then result registered; up to 2 queued.
// Compaction tick: walks past unmapped map entries one by one from the cursor.
// Final tick: walk, header result, full map rebuild, then the second result.
// After reset a pass clears every map entry; input stalls until it ends.
// Synchronous active-low reset; configuration takes reset values at once.
`default_nettype none
module flash_sector_overlay_mapper_top #(
    parameter int MAP_DEPTH     = fsom_pkg::MAP_DEPTH_DEF,
    parameter int SLOT_CAPACITY = fsom_pkg::SLOT_CAPACITY_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [12:0] i_sector,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_status,
    output logic [2:0]       o_command,
    output logic [1:0]       o_source,
    output logic             o_bank,
    output logic [12:0]      o_slot,
    output logic [12:0]      o_from_slot,
    output logic [12:0]      o_record_sector,
    output logic [31:0]      o_sequence_res,
    output logic             o_compacting,
    output logic             o_last
);
    import fsom_pkg::*;

    localparam int LW = $clog2(MAP_DEPTH + 1);
    localparam int SW = $clog2(SLOT_CAPACITY + 1);

    logic [13:0]   r_disk, r_base, r_slots;
    logic [LW-1:0] lim;
    logic [SW-1:0] slots;
    logic          q_valid, pop, busy;
    t_item         q_item;
    t_result       res;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk  <= DISK_RESET;
            r_base  <= BASE_RESET;
            r_slots <= SLOTS_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_DISK:  r_disk  <= pwdata[13:0];
                REG_BASE:  r_base  <= pwdata[13:0];
                REG_SLOTS: r_slots <= pwdata[13:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_DISK:  prdata = {18'd0, r_disk};
            REG_BASE:  prdata = {18'd0, r_base};
            REG_SLOTS: prdata = {18'd0, r_slots};
            default:   prdata = '0;
        endcase
    end

    assign lim   = (32'(r_disk) > 32'(MAP_DEPTH)) ? LW'(MAP_DEPTH) : LW'(r_disk);
    assign slots = (32'(r_slots) > 32'(SLOT_CAPACITY)) ? SW'(SLOT_CAPACITY) : SW'(r_slots);

    fsom_front #(.MAP_DEPTH(MAP_DEPTH)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_func    (i_func),
        .i_sector  (i_sector),
        .i_lim     (lim),
        .i_busy    (busy),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_pop     (pop)
    );

    fsom_back #(.MAP_DEPTH(MAP_DEPTH), .SLOT_CAPACITY(SLOT_CAPACITY)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_lim     (lim),
        .i_slots   (slots),
        .i_base    (r_base),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_pop     (pop),
        .o_busy    (busy),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_res     (res)
    );

    assign o_status        = res.status;
    assign o_command       = res.command;
    assign o_source        = res.source;
    assign o_bank          = res.bank;
    assign o_slot          = res.slot;
    assign o_from_slot     = res.from_slot;
    assign o_record_sector = res.record_sector;
    assign o_sequence_res  = res.sequence_res;
    assign o_compacting    = res.compacting;
    assign o_last          = res.last;

endmodule
`default_nettype wire
